// ----- rtl/core/owf_pkg.sv -----
package owf_pkg;

    // Table depth and the widths that follow from it.
    localparam int WinLen = 32;
    localparam int AddrW  = $clog2(WinLen);
    localparam int LenW   = $clog2(WinLen + 1);

    // Field widths.
    localparam int SampW     = 16;
    localparam int CoefW     = 16;
    localparam int CoefIdxW  = 5;
    localparam int PosW      = 5;
    localparam int ReqW      = 2;
    localparam int StepW     = 16;
    localparam int WinRegW   = 6;
    localparam int CntW      = 17;
    localparam int ProdW     = SampW + CoefW;
    localparam int FracW     = 15;
    localparam int InDataW   = 40;
    localparam int OutDataW  = 24;
    localparam int ApbDataW  = 32;
    localparam int ApbAddrW  = 3;
    localparam int QDepth    = 2;
    localparam int QPtrW     = $clog2(QDepth);

    // Q1.15 rounding and saturation limits.
    localparam int RoundAdd = 1 << (FracW - 1);
    localparam int MaxVal   = 32767;
    localparam int MinVal   = -32768;

    typedef enum logic [ReqW-1:0] {
        REQ_LOAD   = 2'd0,
        REQ_SAMPLE = 2'd1,
        REQ_FLUSH  = 2'd2
    } t_req;

    // Register select, taken from paddr bit 2.
    typedef enum logic {
        REG_STEP    = 1'b0,
        REG_WIN_LEN = 1'b1
    } t_reg;

    typedef enum logic {
        WALK_IDLE,
        WALK_RUN
    } t_walk;

    // One frame to emit: first slot in the line store, number of stored
    // samples in it, frame length, and whether it is the done marker.
    typedef struct packed {
        logic [AddrW-1:0] start;
        logic [LenW-1:0]  have;
        logic [LenW-1:0]  len;
        logic             done;
    } t_job;

    typedef struct packed {
        logic             en;
        logic [AddrW-1:0] addr;
        logic [SampW-1:0] data;
    } t_wr;

    // (a + b) modulo WinLen, for a below WinLen and b up to WinLen.
    function automatic logic [AddrW-1:0] wrap_add(input logic [AddrW-1:0] a,
                                                  input logic [LenW-1:0] b);
        logic [LenW:0] s;
        s = (LenW+1)'(a) + (LenW+1)'(b);
        if (s >= (LenW+1)'(WinLen)) begin
            s = s - (LenW+1)'(WinLen);
        end
        return s[AddrW-1:0];
    endfunction

    // (a - b) modulo WinLen, for a below WinLen and b up to WinLen.
    function automatic logic [AddrW-1:0] wrap_sub(input logic [AddrW-1:0] a,
                                                  input logic [LenW-1:0] b);
        logic [LenW:0] s;
        s = (LenW+1)'(a) + (LenW+1)'(WinLen) - (LenW+1)'(b);
        if (s >= (LenW+1)'(WinLen)) begin
            s = s - (LenW+1)'(WinLen);
        end
        return s[AddrW-1:0];
    endfunction

endpackage

// ----- rtl/core/owf_ram.sv -----
module owf_ram #(
    parameter int Width = 16,
    parameter int Depth = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/owf_front.sv -----
module owf_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [owf_pkg::ReqW-1:0]          i_req,
    input  logic [owf_pkg::SampW-1:0]         i_sample,
    input  logic [owf_pkg::CoefIdxW-1:0]      i_coef_index,
    input  logic [owf_pkg::CoefW-1:0]         i_coef_value,
    input  logic [owf_pkg::LenW-1:0]          i_len,
    input  logic [owf_pkg::StepW-1:0]         i_step,
    input  logic                              i_mem_free,
    input  logic                              i_q_full,
    output owf_pkg::t_wr                      o_line_wr,
    output owf_pkg::t_wr                      o_tab_wr,
    output logic                              o_push,
    output owf_pkg::t_job                     o_job
);

    owf_pkg::t_req                         w_req;
    logic                                  w_accept;
    logic [owf_pkg::AddrW-1:0]             r_ws;
    logic [owf_pkg::AddrW-1:0]             n_ws;
    logic signed [owf_pkg::CntW-1:0]       r_cnt;
    logic signed [owf_pkg::CntW-1:0]       n_cnt;
    logic [owf_pkg::AddrW-1:0]             w_ws_next;
    logic signed [owf_pkg::CntW:0]         w_cnt_x;
    logic signed [owf_pkg::CntW:0]         w_inc;
    logic signed [owf_pkg::CntW:0]         w_win;
    logic signed [owf_pkg::CntW:0]         w_clamp;
    logic signed [owf_pkg::CntW:0]         w_len_s;
    logic signed [owf_pkg::CntW:0]         w_step_s;
    logic signed [owf_pkg::CntW:0]         w_after_samp;
    logic signed [owf_pkg::CntW:0]         w_after_flush;
    logic                                  w_pending;
    logic [owf_pkg::LenW-1:0]              w_c;

    assign w_req    = owf_pkg::t_req'(i_req);
    assign w_accept = i_valid && o_ready;

    // Loads and samples change the memories the back end reads, so they
    // wait until it has nothing queued or running. Flushes only queue work.
    always_comb begin
        unique case (w_req)
            owf_pkg::REQ_LOAD:   o_ready = i_mem_free;
            owf_pkg::REQ_SAMPLE: o_ready = i_mem_free && !i_q_full;
            owf_pkg::REQ_FLUSH:  o_ready = !i_q_full;
            default:             o_ready = 1'b1;
        endcase
    end

    assign w_ws_next     = owf_pkg::wrap_add(r_ws, owf_pkg::LenW'(1));
    assign w_cnt_x       = $signed({r_cnt[owf_pkg::CntW-1], r_cnt});
    assign w_inc         = w_cnt_x + $signed((owf_pkg::CntW+1)'(1));
    assign w_win         = $signed((owf_pkg::CntW+1)'(owf_pkg::WinLen));
    assign w_clamp       = (w_inc > w_win) ? w_win : w_inc;
    assign w_len_s       = $signed((owf_pkg::CntW+1)'(i_len));
    assign w_step_s      = $signed((owf_pkg::CntW+1)'(i_step));
    assign w_after_samp  = w_clamp - w_step_s;
    assign w_after_flush = w_cnt_x - w_step_s;
    assign w_pending     = !r_cnt[owf_pkg::CntW-1] && (r_cnt != '0);
    // The count never exceeds the table depth, so its low bits hold it.
    assign w_c           = r_cnt[owf_pkg::LenW-1:0];

    always_comb begin
        n_ws      = r_ws;
        n_cnt     = r_cnt;
        o_push    = 1'b0;
        o_job     = '0;
        o_line_wr = '0;
        o_tab_wr  = '0;
        if (w_accept) begin
            unique case (w_req)
                owf_pkg::REQ_LOAD: begin
                    o_tab_wr.en   = 32'(i_coef_index) < owf_pkg::WinLen;
                    o_tab_wr.addr = owf_pkg::AddrW'(i_coef_index);
                    o_tab_wr.data = i_coef_value;
                end
                owf_pkg::REQ_SAMPLE: begin
                    o_line_wr.en   = 1'b1;
                    o_line_wr.addr = r_ws;
                    o_line_wr.data = i_sample;
                    n_ws           = w_ws_next;
                    if (w_clamp >= w_len_s) begin
                        o_push     = 1'b1;
                        o_job.start = owf_pkg::wrap_sub(w_ws_next, i_len);
                        o_job.have  = i_len;
                        o_job.len   = i_len;
                        n_cnt       = w_after_samp[owf_pkg::CntW-1:0];
                    end else begin
                        n_cnt = w_clamp[owf_pkg::CntW-1:0];
                    end
                end
                owf_pkg::REQ_FLUSH: begin
                    o_push = 1'b1;
                    if (w_pending) begin
                        o_job.start = owf_pkg::wrap_sub(r_ws, w_c);
                        o_job.have  = (w_c < i_len) ? w_c : i_len;
                        o_job.len   = i_len;
                        n_cnt       = w_after_flush[owf_pkg::CntW-1:0];
                    end else begin
                        // Nothing pending: a single done marker.
                        o_job.len  = owf_pkg::LenW'(1);
                        o_job.done = 1'b1;
                        n_cnt      = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws  <= '0;
            r_cnt <= '0;
        end else begin
            r_ws  <= n_ws;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- rtl/core/owf_queue.sv -----
module owf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  owf_pkg::t_job i_job,
    input  logic          i_pop,
    output owf_pkg::t_job o_job,
    output logic          o_empty,
    output logic          o_full
);

    owf_pkg::t_job                   r_slot [owf_pkg::QDepth];
    logic [owf_pkg::QPtrW-1:0]       r_rd;
    logic [owf_pkg::QPtrW-1:0]       r_wr;
    logic [owf_pkg::QPtrW:0]         r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (owf_pkg::QPtrW+1)'(owf_pkg::QDepth));
    assign o_job   = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + owf_pkg::QPtrW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + owf_pkg::QPtrW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (owf_pkg::QPtrW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (owf_pkg::QPtrW+1)'(1);
            end
        end
    end

endmodule

// ----- rtl/core/owf_back.sv -----
module owf_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_empty,
    input  owf_pkg::t_job                i_job,
    output logic                         o_pop,
    output logic                         o_idle,
    output logic                         o_rd_en,
    output logic [owf_pkg::AddrW-1:0]    o_line_raddr,
    output logic [owf_pkg::AddrW-1:0]    o_tab_raddr,
    input  logic [owf_pkg::SampW-1:0]    i_line_rdata,
    input  logic [owf_pkg::CoefW-1:0]    i_tab_rdata,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [owf_pkg::SampW-1:0]    o_value,
    output logic [owf_pkg::PosW-1:0]     o_pos,
    output logic                         o_end,
    output logic                         o_done
);

    owf_pkg::t_walk                     r_state;
    owf_pkg::t_walk                     n_state;
    owf_pkg::t_job                      r_job;
    logic [owf_pkg::AddrW-1:0]          r_p;
    logic                               w_adv;
    logic                               w_last;
    logic                               w_issue;

    logic                               r_s1_valid;
    logic [owf_pkg::PosW-1:0]           r_s1_pos;
    logic                               r_s1_pad;
    logic                               r_s1_end;
    logic                               r_s1_done;

    logic                               r_s2_valid;
    logic signed [owf_pkg::ProdW-1:0]   r_s2_prod;
    logic [owf_pkg::PosW-1:0]           r_s2_pos;
    logic                               r_s2_pad;
    logic                               r_s2_end;
    logic                               r_s2_done;

    logic signed [owf_pkg::ProdW:0]     w_sum;
    logic signed [owf_pkg::ProdW-owf_pkg::FracW:0] w_shift;
    logic signed [owf_pkg::ProdW-owf_pkg::FracW:0] w_max;
    logic signed [owf_pkg::ProdW-owf_pkg::FracW:0] w_min;
    logic [owf_pkg::SampW-1:0]          w_sat;

    logic                               r_out_valid;
    logic [owf_pkg::SampW-1:0]          r_out_value;
    logic [owf_pkg::PosW-1:0]           r_out_pos;
    logic                               r_out_end;
    logic                               r_out_done;

    // All stages move together whenever the output register can take data.
    assign w_adv  = !r_out_valid || i_ready;
    assign w_last = (owf_pkg::LenW'(r_p) + owf_pkg::LenW'(1)) == r_job.len;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            owf_pkg::WALK_IDLE: begin
                if (!i_q_empty && w_adv) begin
                    n_state = owf_pkg::WALK_RUN;
                end
            end
            owf_pkg::WALK_RUN: begin
                if (w_adv && w_last) begin
                    n_state = owf_pkg::WALK_IDLE;
                end
            end
            default: n_state = owf_pkg::WALK_IDLE;
        endcase
    end

    always_comb begin
        o_pop   = 1'b0;
        w_issue = 1'b0;
        o_idle  = 1'b0;
        unique case (r_state)
            owf_pkg::WALK_IDLE: begin
                o_pop  = !i_q_empty && w_adv;
                o_idle = 1'b1;
            end
            owf_pkg::WALK_RUN: begin
                w_issue = w_adv;
            end
            default: begin
            end
        endcase
    end

    assign o_rd_en      = w_issue;
    assign o_line_raddr = owf_pkg::wrap_add(r_job.start, owf_pkg::LenW'(r_p));
    assign o_tab_raddr  = r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= owf_pkg::WALK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_p   <= '0;
        end else if (w_issue) begin
            r_p <= r_p + owf_pkg::AddrW'(1);
        end
    end

    // Rounding half up to Q1.15, then saturation.
    assign w_sum   = $signed({r_s2_prod[owf_pkg::ProdW-1], r_s2_prod})
                   + $signed((owf_pkg::ProdW+1)'(owf_pkg::RoundAdd));
    assign w_shift = w_sum[owf_pkg::ProdW:owf_pkg::FracW];
    assign w_max   = $signed((owf_pkg::ProdW-owf_pkg::FracW+1)'(owf_pkg::MaxVal));
    assign w_min   = $signed((owf_pkg::ProdW-owf_pkg::FracW+1)'(owf_pkg::MinVal));

    always_comb begin
        if (w_shift > w_max) begin
            w_sat = w_max[owf_pkg::SampW-1:0];
        end else if (w_shift < w_min) begin
            w_sat = w_min[owf_pkg::SampW-1:0];
        end else begin
            w_sat = w_shift[owf_pkg::SampW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= w_issue;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_pos    <= owf_pkg::PosW'(r_p);
            r_s1_pad    <= owf_pkg::LenW'(r_p) >= r_job.have;
            r_s1_end    <= w_last;
            r_s1_done   <= r_job.done;

            r_s2_prod   <= $signed(i_line_rdata) * $signed(i_tab_rdata);
            r_s2_pos    <= r_s1_pos;
            r_s2_pad    <= r_s1_pad;
            r_s2_end    <= r_s1_end;
            r_s2_done   <= r_s1_done;

            r_out_value <= r_s2_pad ? '0 : w_sat;
            r_out_pos   <= r_s2_pos;
            r_out_end   <= r_s2_end;
            r_out_done  <= r_s2_done;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;
    assign o_pos   = r_out_pos;
    assign o_end   = r_out_end;
    assign o_done  = r_out_done;

endmodule

// ----- rtl/core/overlapped_window_framer.sv -----
// Overlapped window framer: cuts a stream of signed 16-bit samples into
// frames that start every step_size samples, window_length values long,
// and multiplies each value by a loaded Q1.15 coefficient.
// Input items arrive on the s_axis channel; tuser carries the request kind
// (coefficient load, sample, or flush) and tdata the sample and coefficient
// fields. Each result item leaves on m_axis with tlast on the last value of
// a frame; tuser marks the done marker that a flush with nothing pending
// gives. Registers step_size and window_length sit on the APB port.
// A sample that completes a frame, or a flush, queues one frame job. The
// back end walks the job one value per cycle while the receiver is ready,
// through a registered memory read and a two-stage multiply. Flushes queue
// up to two jobs ahead; loads and samples wait until the back end has
// finished reading the memories, so a load or sample that follows a sample
// completing a frame is taken only once that frame has been read out.
// Reset clears the write slot, the frame count, the job queue and the
// pipeline valids; coefficients and stored samples must be written before
// use. When the receiver stalls, the whole back end holds; flushes are
// still taken until the queue is full, while loads and samples wait.
module overlapped_window_framer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [15:0] sample, [20:16] coef_index, [36:21] coef_value, [39:37] zero
    input  logic [owf_pkg::InDataW-1:0]      s_axis_tdata,
    // [1:0] req_type
    input  logic [owf_pkg::ReqW-1:0]         s_axis_tuser,

    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [15:0] windowed_value, [20:16] position_in_frame, [23:21] zero
    output logic [owf_pkg::OutDataW-1:0]     m_axis_tdata,
    output logic                             m_axis_tlast,
    // [0] stream_done
    output logic                             m_axis_tuser,

    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [owf_pkg::ApbAddrW-1:0]     paddr,
    input  logic [owf_pkg::ApbDataW-1:0]     pwdata,
    output logic [owf_pkg::ApbDataW-1:0]     prdata,
    output logic                             pready
);

    logic [owf_pkg::StepW-1:0]      r_step;
    logic [owf_pkg::WinRegW-1:0]    r_win_len;
    logic                           w_cfg_wr;
    owf_pkg::t_reg                  w_reg;
    logic [owf_pkg::LenW-1:0]       w_len;
    logic [owf_pkg::StepW-1:0]      w_step;

    owf_pkg::t_wr                   w_line_wr;
    owf_pkg::t_wr                   w_tab_wr;
    logic                           w_push;
    owf_pkg::t_job                  w_push_job;
    owf_pkg::t_job                  w_head_job;
    logic                           w_pop;
    logic                           w_q_empty;
    logic                           w_q_full;
    logic                           w_back_idle;
    logic                           w_rd_en;
    logic [owf_pkg::AddrW-1:0]      w_line_raddr;
    logic [owf_pkg::AddrW-1:0]      w_tab_raddr;
    logic [owf_pkg::SampW-1:0]      w_line_rdata;
    logic [owf_pkg::CoefW-1:0]      w_tab_rdata;
    logic [owf_pkg::SampW-1:0]      w_value;
    logic [owf_pkg::PosW-1:0]       w_pos;

    // Configuration registers. Only address bit 2 selects the register.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_reg    = owf_pkg::t_reg'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= owf_pkg::StepW'(16);
            r_win_len <= owf_pkg::WinRegW'(owf_pkg::WinLen);
        end else if (w_cfg_wr) begin
            unique case (w_reg)
                owf_pkg::REG_STEP:    r_step    <= pwdata[owf_pkg::StepW-1:0];
                owf_pkg::REG_WIN_LEN: r_win_len <= pwdata[owf_pkg::WinRegW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            owf_pkg::REG_STEP:    prdata = owf_pkg::ApbDataW'(r_step);
            owf_pkg::REG_WIN_LEN: prdata = owf_pkg::ApbDataW'(r_win_len);
            default:              prdata = '0;
        endcase
    end

    // A zero length acts as one, and a length beyond the table as the
    // table depth; a zero step acts as one.
    always_comb begin
        if (r_win_len == '0) begin
            w_len = owf_pkg::LenW'(1);
        end else if (32'(r_win_len) > owf_pkg::WinLen) begin
            w_len = owf_pkg::LenW'(owf_pkg::WinLen);
        end else begin
            w_len = owf_pkg::LenW'(r_win_len);
        end
    end

    assign w_step = (r_step == '0) ? owf_pkg::StepW'(1) : r_step;

    owf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_req        (s_axis_tuser),
        .i_sample     (s_axis_tdata[15:0]),
        .i_coef_index (s_axis_tdata[20:16]),
        .i_coef_value (s_axis_tdata[36:21]),
        .i_len        (w_len),
        .i_step       (w_step),
        .i_mem_free   (w_q_empty && w_back_idle),
        .i_q_full     (w_q_full),
        .o_line_wr    (w_line_wr),
        .o_tab_wr     (w_tab_wr),
        .o_push       (w_push),
        .o_job        (w_push_job)
    );

    owf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    // Recent samples, written in a circle at the write slot.
    owf_ram #(
        .Width (owf_pkg::SampW),
        .Depth (owf_pkg::WinLen)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_line_wr.en),
        .i_waddr (w_line_wr.addr),
        .i_wdata (w_line_wr.data),
        .i_re    (w_rd_en),
        .i_raddr (w_line_raddr),
        .o_rdata (w_line_rdata)
    );

    // Window coefficients, one per frame position.
    owf_ram #(
        .Width (owf_pkg::CoefW),
        .Depth (owf_pkg::WinLen)
    ) u_tab_ram (
        .i_clk   (i_clk),
        .i_we    (w_tab_wr.en),
        .i_waddr (w_tab_wr.addr),
        .i_wdata (w_tab_wr.data),
        .i_re    (w_rd_en),
        .i_raddr (w_tab_raddr),
        .o_rdata (w_tab_rdata)
    );

    owf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (w_q_empty),
        .i_job        (w_head_job),
        .o_pop        (w_pop),
        .o_idle       (w_back_idle),
        .o_rd_en      (w_rd_en),
        .o_line_raddr (w_line_raddr),
        .o_tab_raddr  (w_tab_raddr),
        .i_line_rdata (w_line_rdata),
        .i_tab_rdata  (w_tab_rdata),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_value      (w_value),
        .o_pos        (w_pos),
        .o_end        (m_axis_tlast),
        .o_done       (m_axis_tuser)
    );

    assign m_axis_tdata = {
        (owf_pkg::OutDataW - owf_pkg::SampW - owf_pkg::PosW)'(0),
        w_pos,
        w_value
    };

endmodule

// ----- dv/tb.sv -----
// Testbench for the overlapped window framer.
//
// The bench keeps its own model of the framer: the sample history, the
// coefficient table, the write slot and the count of samples since the start
// of the oldest pending frame. Every item accepted on the input stream is
// pushed through that model, and the values it yields are queued as the
// expected output. A checker pops the queue on every output handshake and
// compares the four result fields one by one.
//
// The run is a short directed test of the corner cases. A second test loads
// the whole coefficient table. A third test sweeps through a list of hop and
// window settings with random traffic, including the out-of-range register
// values. The sender works in bursts with random gaps. The receiver stalls in
// modes that change at random intervals. A watchdog ends the run if nothing
// moves for too long.
module tb;
    import owf_pkg::*;

    // The request code that the block has to ignore.
    localparam logic [ReqW-1:0] ReqUnused = 2'd3;

    // Cycles without any handshake before the run is declared hung. The worst
    // honest stretch is a settle pause plus a long run of receiver stalls, far
    // below this.
    localparam int IdleLimit        = 5000;
    // Quiet cycles after the last result before a register write. This covers
    // the pipeline plus a full frame walk of the back end.
    localparam int SettleCycles     = 48;
    localparam int ItemsPerSetting  = 14;
    localparam int MaxPrintedErrors = 40;

    typedef struct packed {
        logic signed [SampW-1:0] value;
        logic [PosW-1:0]         pos;
        logic                    last;
        logic                    done;
    } t_frame_value;

    // Clock, reset and the block's ports; the ones the bench drives are known from time zero.
    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata  = '0;
    logic [ReqW-1:0]     s_axis_tuser  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;
    logic                m_axis_tlast;
    logic                m_axis_tuser;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [ApbAddrW-1:0] paddr         = '0;
    logic [ApbDataW-1:0] pwdata        = '0;
    logic [ApbDataW-1:0] prdata;
    logic                pready;

    // Model state of the framer. Registers start at their reset values.
    logic signed [SampW-1:0] sample_history [WinLen];
    logic signed [CoefW-1:0] coef_table [WinLen];
    logic [AddrW-1:0]        history_slot = '0;
    int                      fill_count   = 0;
    logic [StepW-1:0]        hop_reg      = 16'd16;
    logic [WinRegW-1:0]      len_reg      = 6'd32;
    bit                      flush_hit_done;

    t_frame_value frame_values_due [$];
    int           mismatches  = 0;
    int           items_sent  = 0;
    int           burst_left  = 0;
    int           idle_cycles = 0;
    int           rx_mode     = 0;
    int           rx_left     = 0;

    overlapped_window_framer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void note_mismatch(input string what, input longint want,
                                          input longint got);
        mismatches++;
        if (mismatches <= MaxPrintedErrors) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endfunction

    // A window length of zero behaves as one, and anything past the table
    // depth behaves as the full table.
    function automatic int active_len();
        if (len_reg == 0) begin
            return 1;
        end
        if (len_reg > WinLen) begin
            return WinLen;
        end
        return int'(len_reg);
    endfunction

    // A hop of zero behaves as a hop of one.
    function automatic int active_hop();
        return (hop_reg == 0) ? 1 : int'(hop_reg);
    endfunction

    // Q1.15 times Q1.15. Half an LSB is added, then the arithmetic shift
    // floors the result, which rounds half up. The result is clamped to 16
    // bits, so only -1.0 times -1.0 can overflow.
    function automatic logic signed [SampW-1:0] q15_product(input logic signed [SampW-1:0] s,
                                                            input logic signed [CoefW-1:0] c);
        longint acc;
        acc = (longint'(s) * longint'(c) + longint'(RoundAdd)) >>> FracW;
        if (acc > MaxVal) begin
            acc = MaxVal;
        end else if (acc < MinVal) begin
            acc = MinVal;
        end
        return acc[SampW-1:0];
    endfunction

    // Queue one frame whose first sample sits 'back' slots behind the write
    // slot. Only the first 'have' positions hold real samples. The positions
    // after them are zero padding.
    function automatic void queue_frame(input int back, input int have, input int len);
        int           first;
        t_frame_value v;
        first = (int'(history_slot) + WinLen - back) % WinLen;
        for (int p = 0; p < len; p++) begin
            v.value = (p < have) ?
                      q15_product(sample_history[(first + p) % WinLen], coef_table[p]) : '0;
            v.pos   = PosW'(p);
            v.last  = (p == len - 1);
            v.done  = 1'b0;
            frame_values_due.push_back(v);
        end
    endfunction

    // Advance the model by one accepted item and queue what it should emit.
    function automatic void predict_frame_values(input logic [ReqW-1:0] kind,
                                                 input logic [SampW-1:0] smp,
                                                 input logic [CoefIdxW-1:0] idx,
                                                 input logic [CoefW-1:0] cv);
        int           len;
        int           hop;
        int           pending;
        t_frame_value marker;
        len            = active_len();
        hop            = active_hop();
        flush_hit_done = 1'b0;
        case (kind)
            REQ_LOAD: begin
                coef_table[idx] = cv;
            end
            REQ_SAMPLE: begin
                sample_history[history_slot] = smp;
                history_slot                 = history_slot + 1'b1;
                // The count saturates at the table depth.
                fill_count = (fill_count >= WinLen) ? WinLen : fill_count + 1;
                if (fill_count >= len) begin
                    queue_frame(len, len, len);
                    fill_count -= hop;
                end
            end
            REQ_FLUSH: begin
                if (fill_count <= 0) begin
                    // Nothing is pending, so the flush gives the done marker
                    // and clears the count, which may be negative inside a gap.
                    marker.value = '0;
                    marker.pos   = '0;
                    marker.last  = 1'b1;
                    marker.done  = 1'b1;
                    frame_values_due.push_back(marker);
                    fill_count     = 0;
                    flush_hit_done = 1'b1;
                end else begin
                    pending     = fill_count;
                    fill_count -= hop;
                    queue_frame(pending, (pending < len) ? pending : len, len);
                end
            end
            default: begin
                // The block ignores unknown requests.
            end
        endcase
    endfunction

    // Present one item and hold it until it is taken. The valid stays high
    // afterwards, so the next call either keeps the burst going in the same
    // time step or lowers valid for a gap.
    task automatic send_item(input logic [ReqW-1:0] kind, input logic [SampW-1:0] smp,
                             input logic [CoefIdxW-1:0] idx, input logic [CoefW-1:0] cv);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= InDataW'({cv, idx, smp});
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        predict_frame_values(kind, smp, idx, cv);
        burst_left--;
        if (kind != ReqUnused) begin
            items_sent++;
        end
    endtask

    // Stop sending and wait until every expected value has come back, then
    // wait out the 'settle' pause. The task always waits for a clock edge, so
    // valid is never lowered and raised again in the same step.
    task automatic wait_for_drain(input int settle);
        s_axis_tvalid <= 1'b0;
        burst_left     = 0;
        do @(posedge i_clk); while (frame_values_due.size() > 0);
        repeat (settle) @(posedge i_clk);
    endtask

    // An APB write followed by a read-back of the same register. The stored
    // value is masked to the register's width. The bus is left idle at the
    // end, so back-to-back calls never drive it twice in a step.
    task automatic write_register(input t_reg sel, input logic [ApbDataW-1:0] value,
                                  input logic [ApbDataW-1:0] mask);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== (value & mask)) begin
            note_mismatch("register read-back", longint'(value & mask), longint'(prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Register writes happen only when the block is idle.
    task automatic program_framer(input logic [StepW-1:0] hop, input logic [WinRegW-1:0] len);
        wait_for_drain(SettleCycles);
        write_register(REG_STEP, ApbDataW'(hop), 32'h0000_FFFF);
        write_register(REG_WIN_LEN, ApbDataW'(len), 32'h0000_003F);
        hop_reg = hop;
        len_reg = len;
    endtask

    // Random 16-bit word that often lands on a full-scale or zero value.
    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 11))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // One item of any kind, the ignored code included, with random fields.
    task automatic send_noise();
        send_item(2'($urandom_range(0, 3)), rand_word(), 5'($urandom), rand_word());
    endtask

    // A well-formed stretch of work: a run of samples with the odd
    // coefficient reload in between, then flushes until the done marker
    // shows that no frame is pending.
    task automatic send_segment();
        int runs;
        runs = $urandom_range(0, 40);
        repeat (runs) begin
            if ($urandom_range(0, 11) == 0) begin
                send_item(REQ_LOAD, rand_word(), 5'($urandom), rand_word());
            end
            send_item(REQ_SAMPLE, rand_word(), 5'($urandom), rand_word());
        end
        do begin
            send_item(REQ_FLUSH, rand_word(), 5'($urandom), rand_word());
        end while (!flush_hit_done);
    endtask

    task automatic run_setting(input logic [StepW-1:0] hop, input logic [WinRegW-1:0] len);
        int target;
        program_framer(hop, len);
        target = items_sent + ItemsPerSetting;
        while (items_sent < target) begin
            if ($urandom_range(0, 4) == 0) begin
                send_noise();
            end else begin
                send_segment();
            end
            // Now and then the sender holds off until the output is empty.
            if ($urandom_range(0, 30) == 0) begin
                wait_for_drain(0);
            end
        end
    endtask

    // Corner cases on a short window. The coefficients include both full-scale values, and
    // the first sample against -1.0 saturates to the largest positive value.
    // The test covers a flush with nothing pending, a flush of a padded tail
    // frame, the ignored request code and a load of the top table entry.
    task automatic test_directed_corners();
        program_framer(16'd2, 6'd4);
        send_item(REQ_FLUSH, 16'h0000, 5'd0, 16'h0000);
        send_item(REQ_LOAD, 16'h0000, 5'd0, 16'h8000);
        send_item(REQ_LOAD, 16'hFFFF, 5'd1, 16'h7FFF);
        send_item(REQ_LOAD, 16'h0000, 5'd2, 16'hFFFF);
        send_item(REQ_LOAD, 16'h0000, 5'd3, 16'h4000);
        send_item(REQ_LOAD, 16'h0000, 5'd31, 16'h7FFF);
        send_item(ReqUnused, 16'hFFFF, 5'd31, 16'hFFFF);
        send_item(REQ_SAMPLE, 16'h8000, 5'd0, 16'h0000);
        send_item(REQ_SAMPLE, 16'h7FFF, 5'd0, 16'h0000);
        send_item(REQ_SAMPLE, 16'h8000, 5'd0, 16'h0000);
        send_item(REQ_SAMPLE, 16'h7FFF, 5'd31, 16'hFFFF);
        send_item(REQ_SAMPLE, 16'hFFFF, 5'd0, 16'h0000);
        send_item(REQ_SAMPLE, 16'h0001, 5'd0, 16'h0000);
        send_item(REQ_FLUSH, 16'h0000, 5'd0, 16'h0000);
        send_item(REQ_FLUSH, 16'h0000, 5'd0, 16'h0000);
        send_item(REQ_FLUSH, 16'h0000, 5'd0, 16'h0000);
    endtask

    // Every table entry gets written before any window can reach it.
    task automatic test_coef_table();
        program_framer(16'd16, 6'd32);
        for (int i = 0; i < WinLen; i++) begin
            send_item(REQ_LOAD, rand_word(), CoefIdxW'(i), rand_word());
        end
    endtask

    // Random traffic under a range of settings. The list includes a zero hop,
    // a zero window length, a length beyond the table and the largest hop.
    task automatic test_framing_sweep();
        run_setting(16'd1, 6'd1);
        run_setting(16'd0, 6'd0);
        run_setting(16'd3, 6'd8);
        run_setting(16'd8, 6'd8);
        run_setting(16'd32, 6'd32);
        run_setting(16'd5, 6'd63);
        run_setting(16'd65535, 6'd17);
        run_setting(16'd40, 6'd12);
        run_setting(16'd2, 6'd31);
        run_setting(16'd1, 6'd32);
        run_setting(16'd7, 6'd5);
    endtask

    // The receiver switches at random intervals between four modes: always
    // ready, ready half the time, ready rarely, and a fixed five-of-eight
    // pattern.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(16, 96);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ((rx_left % 8) < 5);
        endcase
    end

    // Compare each accepted output value with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_frame_value want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (frame_values_due.size() == 0) begin
                note_mismatch("unexpected output value", 0, $signed(m_axis_tdata[15:0]));
            end else begin
                want = frame_values_due.pop_front();
                if ($signed(m_axis_tdata[15:0]) != want.value) begin
                    note_mismatch("windowed_value", want.value, $signed(m_axis_tdata[15:0]));
                end
                if (m_axis_tdata[20:16] != want.pos) begin
                    note_mismatch("position_in_frame", want.pos, m_axis_tdata[20:16]);
                end
                if (m_axis_tlast != want.last) begin
                    note_mismatch("frame_end", want.last, m_axis_tlast);
                end
                if (m_axis_tuser != want.done) begin
                    note_mismatch("stream_done", want.done, m_axis_tuser);
                end
            end
        end
    end

    // A handshake on any port restarts the count. A long quiet stretch means
    // the block has stopped answering.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("[overlapped_window_framer] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_corners();
        test_coef_table();
        test_framing_sweep();
        wait_for_drain(SettleCycles);
        if (mismatches == 0 && frame_values_due.size() == 0) begin
            $display("[overlapped_window_framer] OK");
        end else begin
            $display("[overlapped_window_framer] ERROR");
        end
        $finish;
    end

endmodule

// ----- overlapped_window_framer.f -----
rtl/core/owf_pkg.sv
rtl/core/owf_ram.sv
rtl/core/owf_front.sv
rtl/core/owf_queue.sv
rtl/core/owf_back.sv
rtl/core/overlapped_window_framer.sv
dv/tb.sv
